### hw/rtl/lli_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, dry-air tables, request/response types and the constant log2.
package lli_pkg;

  localparam int TABLE_POINTS    = 26;
  localparam int COEFF_FRAC_BITS = 32;
  localparam int QBITS           = 30;
  localparam int EW              = 24;             // energy width
  localparam int CW              = 32;             // coefficient width
  localparam int IW              = $clog2(TABLE_POINTS);
  localparam int NW              = 5;              // integer part of a log2
  localparam int MW              = QBITS + 1;      // Q30 mantissa in [1,2)
  localparam int LW              = NW + QBITS;     // log2 value, unsigned
  localparam int DW              = 31;             // interpolation num / den
  localparam int GW              = 32;             // |delta log value|
  localparam int QW              = GW;             // divider quotient
  localparam int PW              = DW + GW;        // num * mag
  localparam int YW              = LW + 3;         // signed exponent before clamp
  localparam int ZW              = YW - 1;         // exponent after clamp
  localparam int KW              = ZW - QBITS;     // integer part of exponent
  localparam int XW              = QBITS;          // exp argument
  localparam int TW              = QBITS + 1;      // Taylor term
  localparam int SW              = 32;             // Taylor sum / mantissa
  localparam int EXP_TERMS       = 16;
  localparam int MAGIC_S         = QBITS + 4;      // reciprocal shift for n <= 16
  localparam int MGW             = MAGIC_S;        // reciprocal width for n >= 2
  localparam int MICRO_SCALE     = 1000000;
  localparam logic [XW-1:0] LN2_Q = 30'd744261118;

  // request to response, in cycles
  localparam int LATENCY = 2 + QBITS + 2 + QW + 1 + 2 * EXP_TERMS + 2 + 1;

  localparam logic [31:0] GRID_EV [TABLE_POINTS] = '{
    10000, 15000, 20000, 30000, 40000, 50000, 60000, 80000, 100000,
    150000, 200000, 300000, 400000, 500000, 600000, 800000, 1000000,
    1250000, 1500000, 2000000, 3000000, 4000000, 5000000, 6000000,
    8000000, 10000000
  };

  // micro m^2/kg
  localparam logic [31:0] ATTEN_MICRO [TABLE_POINTS] = '{
    512000, 161400, 77790, 35380, 24850, 20800, 18750, 16620, 15410,
    13560, 12330, 10670, 9549, 8712, 8055, 7074, 6358, 5687, 5175,
    4447, 3581, 3079, 2751, 2522, 2225, 2045
  };

  localparam logic [31:0] ABSORB_MICRO [TABLE_POINTS] = '{
    474200, 133400, 53890, 15370, 6833, 4098, 3041, 2407, 2325,
    2496, 2672, 2872, 2949, 2966, 2953, 2882, 2789, 2666, 2547,
    2345, 2057, 1870, 1740, 1647, 1525, 1450
  };

  typedef struct packed {
    logic [EW-1:0] energy_ev;
    logic          operation;
  } lli_in_t;

  typedef struct packed {
    logic [CW-1:0] coefficient;
    logic          out_of_range;
  } lli_out_t;

  // sideband through the log2 pipeline
  typedef struct packed {
    logic          op;
    logic          oor;
    logic          lo_cl;
    logic          hi_cl;
    logic [IW-1:0] idx;
  } lg_sb_t;

  // sideband through the divider
  typedef struct packed {
    logic                 oor;
    logic                 neg;
    logic signed [YW-1:0] base;
  } div_sb_t;

  // sideband through the exp2 pipeline
  typedef struct packed {
    logic          oor;
    logic [KW-1:0] k;
  } exp_sb_t;

  // Q30 log2 by square-and-compare; used on constants only
  function automatic logic [LW-1:0] log2_q(input logic [31:0] x);
    logic [31:0]   xv;
    logic [63:0]   m;
    logic [LW-1:0] r;
    int            n;
    xv = (x == 32'd0) ? 32'd1 : x;
    n  = 0;
    for (int i = 0; i < 32; i++) begin
      if (xv[i]) n = i;
    end
    m = (64'(xv) << QBITS) >> n;
    r = LW'(n) << QBITS;
    for (int b = QBITS - 1; b >= 0; b--) begin
      m = (m * m) >> QBITS;
      if (m >= (64'd2 << QBITS)) begin
        m    = m >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  localparam logic [LW-1:0] LOG_MICRO = log2_q(32'(MICRO_SCALE));

  // exponent offset: frac bits minus log2 of the micro scale
  localparam logic signed [YW-1:0] ZOFS =
    YW'((longint'(COEFF_FRAC_BITS) <<< QBITS) - longint'(LOG_MICRO));

endpackage

### hw/rtl/lli_log2.sv
`timescale 1ns / 1ps
// Pipelined Q30 log2: one square-and-compare fraction bit per stage.
module lli_log2
  import lli_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [MW-1:0]  in_mant,
  input  logic [NW-1:0]  in_int,
  input  lg_sb_t         in_sb,
  output logic           out_valid,
  output logic [LW-1:0]  out_log,
  output lg_sb_t         out_sb
);

  logic             v_r  [QBITS];
  logic [MW-1:0]    m_r  [QBITS];
  logic [QBITS-1:0] f_r  [QBITS];
  logic [NW-1:0]    n_r  [QBITS];
  lg_sb_t           sb_r [QBITS];

  for (genvar s = 0; s < QBITS; s++) begin : g_sq
    logic             v_in;
    logic [MW-1:0]    m_in;
    logic [QBITS-1:0] f_in;
    logic [NW-1:0]    n_in;
    lg_sb_t           sb_in;
    logic [2*MW-1:0]  sq;
    logic [MW:0]      m2;

    if (s == 0) begin : g_head
      assign v_in  = in_valid;
      assign m_in  = in_mant;
      assign f_in  = '0;
      assign n_in  = in_int;
      assign sb_in = in_sb;
    end else begin : g_tail
      assign v_in  = v_r[s-1];
      assign m_in  = m_r[s-1];
      assign f_in  = f_r[s-1];
      assign n_in  = n_r[s-1];
      assign sb_in = sb_r[s-1];
    end

    // square, truncate back to Q30; >= 2 yields a one bit and a halving
    assign sq = m_in * m_in;
    assign m2 = sq[QBITS +: MW+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      m_r[s]  <= m2[MW] ? m2[MW:1] : m2[MW-1:0];
      f_r[s]  <= {f_in[QBITS-2:0], m2[MW]};
      n_r[s]  <= n_in;
      sb_r[s] <= sb_in;
    end
  end

  assign out_valid = v_r[QBITS-1];
  assign out_log   = {n_r[QBITS-1], f_r[QBITS-1]};
  assign out_sb    = sb_r[QBITS-1];

endmodule

### hw/rtl/lli_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, truncating.
module lli_div
  import lli_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [PW-1:0] in_p,
  input  logic [DW-1:0] in_den,
  input  div_sb_t       in_sb,
  output logic          out_valid,
  output logic [QW-1:0] out_q,
  output div_sb_t       out_sb
);

  logic          v_r   [QW];
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] den_r [QW];
  div_sb_t       sb_r  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [DW-1:0] den_in;
    div_sb_t       sb_in;
    logic [DW:0]   trial;
    logic          fits;

    // quotient fits QW bits, so the upper dividend part starts below den
    if (s == 0) begin : g_head
      assign v_in   = in_valid;
      assign rem_in = in_p[PW-1:QW];
      assign low_in = in_p[QW-1:0];
      assign q_in   = '0;
      assign den_in = in_den;
      assign sb_in  = in_sb;
    end else begin : g_tail
      assign v_in   = v_r[s-1];
      assign rem_in = rem_r[s-1];
      assign low_in = low_r[s-1];
      assign q_in   = q_r[s-1];
      assign den_in = den_r[s-1];
      assign sb_in  = sb_r[s-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= fits ? DW'(trial - {1'b0, den_in}) : DW'(trial);
      low_r[s] <= low_in << 1;
      q_r[s]   <= {q_in[QW-2:0], fits};
      den_r[s] <= den_in;
      sb_r[s]  <= sb_in;
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_q     = q_r[QW-1];
  assign out_sb    = sb_r[QW-1];

endmodule

### hw/rtl/lli_exp.sv
`timescale 1ns / 1ps
// Pipelined Q30 exp2 of the exponent fraction: Taylor series, two stages per term.
module lli_exp
  import lli_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [ZW-1:0] in_z,
  input  logic          in_oor,
  output logic          out_valid,
  output logic [SW-1:0] out_mant,
  output exp_sb_t       out_sb
);

  logic            x_v_r;
  logic [XW-1:0]   x_r;
  exp_sb_t         x_sb_r;
  logic [2*XW-1:0] xprod;

  logic          a_v_r   [EXP_TERMS];
  logic [TW-1:0] a_val_r [EXP_TERMS];
  logic [SW-1:0] a_sum_r [EXP_TERMS];
  logic [XW-1:0] a_x_r   [EXP_TERMS];
  exp_sb_t       a_sb_r  [EXP_TERMS];

  logic          b_v_r    [EXP_TERMS];
  logic [TW-1:0] b_term_r [EXP_TERMS];
  logic [SW-1:0] b_sum_r  [EXP_TERMS];
  logic [XW-1:0] b_x_r    [EXP_TERMS];
  exp_sb_t       b_sb_r   [EXP_TERMS];

  logic          o_v_r;
  logic [SW-1:0] o_mant_r;
  exp_sb_t       o_sb_r;

  // argument x = frac * ln2
  assign xprod = in_z[QBITS-1:0] * LN2_Q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r <= 1'b0;
    end else begin
      x_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= xprod[QBITS +: XW];
    x_sb_r.oor <= in_oor;
    x_sb_r.k   <= in_z[ZW-1:QBITS];
  end

  for (genvar i = 0; i < EXP_TERMS; i++) begin : g_term
    logic             v_in;
    logic [TW-1:0]    t_in;
    logic [SW-1:0]    s_in;
    logic [XW-1:0]    x_in;
    exp_sb_t          sb_in;
    logic [TW+XW-1:0] tprod;
    logic [TW-1:0]    q;

    if (i == 0) begin : g_head
      assign v_in  = x_v_r;
      assign t_in  = TW'(1) << QBITS;
      assign s_in  = '0;
      assign x_in  = x_r;
      assign sb_in = x_sb_r;
    end else begin : g_tail
      assign v_in  = b_v_r[i-1];
      assign t_in  = b_term_r[i-1];
      assign s_in  = b_sum_r[i-1];
      assign x_in  = b_x_r[i-1];
      assign sb_in = b_sb_r[i-1];
    end

    // product stage; the previous term joins the sum alongside
    assign tprod = t_in * x_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_v_r[i] <= 1'b0;
        b_v_r[i] <= 1'b0;
      end else begin
        a_v_r[i] <= v_in;
        b_v_r[i] <= a_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      a_val_r[i] <= tprod[QBITS +: TW];
      a_sum_r[i] <= s_in + SW'(t_in);
      a_x_r[i]   <= x_in;
      a_sb_r[i]  <= sb_in;
    end

    // divide by the term number: exact reciprocal multiply for values below 2^30
    if (i == 0) begin : g_unit
      assign q = a_val_r[i];
    end else begin : g_recip
      localparam logic [MGW-1:0] RECIP =
        MGW'(((64'd1 << MAGIC_S) + 64'(i)) / 64'(i + 1));
      logic [TW+MGW-1:0] rprod;
      assign rprod = a_val_r[i] * RECIP;
      assign q     = rprod[MAGIC_S +: TW];
    end

    always_ff @(posedge clk) begin
      b_term_r[i] <= q;
      b_sum_r[i]  <= a_sum_r[i];
      b_x_r[i]    <= a_x_r[i];
      b_sb_r[i]   <= a_sb_r[i];
    end
  end

  // last term into the sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else begin
      o_v_r <= b_v_r[EXP_TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    o_mant_r <= b_sum_r[EXP_TERMS-1] + SW'(b_term_r[EXP_TERMS-1]);
    o_sb_r   <= b_sb_r[EXP_TERMS-1];
  end

  assign out_valid = o_v_r;
  assign out_mant  = o_mant_r;
  assign out_sb    = o_sb_r;

endmodule

### hw/rtl/log_log_coefficient_interpolator.sv
`timescale 1ns / 1ps
// Usage:
//   Request: in_req (energy_ev in whole eV, operation 0 = mass attenuation,
//   1 = mass energy absorption), taken at a rising edge with start high and
//   busy low. Response: out_rsp (coefficient in m^2/kg scaled by 2^32 and the
//   out_of_range flag), shown for one cycle with out_valid high.
//   From the accepting edge to the edge that takes the response, a request
//   passes the input register, interval search, 30 log2 stages, interval
//   setup, product, 32 divider stages, exponent, 34 exp2 stages, output shift.
//   Throughput: one request per cycle while busy is low, back to back, with no gaps.
//   Each pipeline stage holds one request and a valid bit; nothing stalls,
//   and the receiver cannot hold responses off.
//   Reset (rst_n low, synchronous): all valid bits clear, requests in flight
//   are dropped and busy is high until the first edge after reset releases.
//   After that busy stays low.
module log_log_coefficient_interpolator
  import lli_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lli_in_t  in_req,
  output logic     out_valid,
  output lli_out_t out_rsp
);

  // constant log2 tables
  logic [LW-1:0] log_grid [TABLE_POINTS];
  logic [LW-1:0] log_att  [TABLE_POINTS];
  logic [LW-1:0] log_abs  [TABLE_POINTS];

  for (genvar i = 0; i < TABLE_POINTS; i++) begin : g_tab
    localparam logic [LW-1:0] LG = log2_q(GRID_EV[i]);
    localparam logic [LW-1:0] LA = log2_q(ATTEN_MICRO[i]);
    localparam logic [LW-1:0] LB = log2_q(ABSORB_MICRO[i]);
    assign log_grid[i] = LG;
    assign log_att[i]  = LA;
    assign log_abs[i]  = LB;
  end

  logic busy_r;

  logic          s0_valid_r;
  logic [EW-1:0] s0_e_r;
  logic          s0_op_r;

  logic [IW-1:0] s1_cnt;
  logic [EW-1:0] s1_e1;
  logic [NW-1:0] s1_n;
  logic          s1_valid_r;
  logic [MW-1:0] s1_mant_r;
  logic [NW-1:0] s1_n_r;
  lg_sb_t        s1_sb_r;

  logic          lg_valid;
  logic [LW-1:0] lg_log;
  lg_sb_t        lg_sb;

  logic [IW-1:0]       s2_lo;
  logic [LW-1:0]       s2_lglo;
  logic [LW-1:0]       s2_lghi;
  logic [LW-1:0]       s2_vlo;
  logic [LW-1:0]       s2_vhi;
  logic [DW-1:0]       s2_den;
  logic [DW-1:0]       s2_num;
  logic signed [LW:0]  s2_numf;
  logic                s2_neg;
  logic                s2_valid_r;
  logic [DW-1:0]       s2_num_r;
  logic [DW-1:0]       s2_den_r;
  logic [GW-1:0]       s2_mag_r;
  div_sb_t             s2_sb_r;

  logic [PW-1:0] s3_prod;
  logic          s3_valid_r;
  logic [PW-1:0] s3_p_r;
  logic [DW-1:0] s3_den_r;
  div_sb_t       s3_sb_r;

  logic          dv_valid;
  logic [QW-1:0] dv_q;
  div_sb_t       dv_sb;

  logic signed [YW-1:0] s4_y;
  logic                 s4_valid_r;
  logic [ZW-1:0]        s4_z_r;
  logic                 s4_oor_r;

  logic          ex_valid;
  logic [SW-1:0] ex_mant;
  exp_sb_t       ex_sb;

  logic [KW-1:0]   s5_sh;
  logic [2*CW-1:0] s5_wide;
  logic [CW-1:0]   s5_res;
  logic            out_valid_r;
  lli_out_t        out_rsp_r;

  // busy only through reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_e_r  <= in_req.energy_ev;
    s0_op_r <= in_req.operation;
  end

  // interval search and normalization for log2
  always_comb begin
    s1_cnt = '0;
    for (int i = 1; i < TABLE_POINTS - 1; i++) begin
      if (GRID_EV[i] < 32'(s0_e_r)) s1_cnt = s1_cnt + IW'(1);
    end
    s1_e1 = (s0_e_r == '0) ? EW'(1) : s0_e_r;
    s1_n  = '0;
    for (int i = 0; i < EW; i++) begin
      if (s1_e1[i]) s1_n = NW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_mant_r     <= MW'(s1_e1) << (NW'(QBITS) - s1_n);
    s1_n_r        <= s1_n;
    s1_sb_r.op    <= s0_op_r;
    s1_sb_r.oor   <= (32'(s0_e_r) < GRID_EV[0]) ||
                     (32'(s0_e_r) > GRID_EV[TABLE_POINTS-1]);
    s1_sb_r.lo_cl <= 32'(s0_e_r) <= GRID_EV[0];
    s1_sb_r.hi_cl <= 32'(s0_e_r) >= GRID_EV[TABLE_POINTS-1];
    s1_sb_r.idx   <= s1_cnt + IW'(1);
  end

  lli_log2 u_log2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_mant   (s1_mant_r),
    .in_int    (s1_n_r),
    .in_sb     (s1_sb_r),
    .out_valid (lg_valid),
    .out_log   (lg_log),
    .out_sb    (lg_sb)
  );

  // interval setup; clamped energies pin num to 0 or den
  always_comb begin
    s2_lo   = lg_sb.idx - IW'(1);
    s2_lglo = log_grid[s2_lo];
    s2_lghi = log_grid[lg_sb.idx];
    s2_vlo  = lg_sb.op ? log_abs[s2_lo] : log_att[s2_lo];
    s2_vhi  = lg_sb.op ? log_abs[lg_sb.idx] : log_att[lg_sb.idx];
    s2_den  = DW'(s2_lghi - s2_lglo);
    s2_numf = $signed({1'b0, lg_log}) - $signed({1'b0, s2_lglo});
    s2_neg  = s2_vhi < s2_vlo;
    priority if (lg_sb.lo_cl) begin
      s2_num = '0;
    end else if (lg_sb.hi_cl) begin
      s2_num = s2_den;
    end else if (s2_numf < 0) begin
      s2_num = '0;
    end else if (s2_numf > $signed({{(LW+1-DW){1'b0}}, s2_den})) begin
      s2_num = s2_den;
    end else begin
      s2_num = DW'(s2_numf);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= lg_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_num_r     <= s2_num;
    s2_den_r     <= s2_den;
    s2_mag_r     <= s2_neg ? GW'(s2_vlo - s2_vhi) : GW'(s2_vhi - s2_vlo);
    s2_sb_r.oor  <= lg_sb.oor;
    s2_sb_r.neg  <= s2_neg;
    s2_sb_r.base <= $signed(YW'(s2_vlo)) + ZOFS;
  end

  // num * |dv|
  assign s3_prod = s2_num_r * s2_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_p_r   <= s3_prod;
    s3_den_r <= s2_den_r;
    s3_sb_r  <= s2_sb_r;
  end

  lli_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid_r),
    .in_p      (s3_p_r),
    .in_den    (s3_den_r),
    .in_sb     (s3_sb_r),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_sb    (dv_sb)
  );

  // exponent, clamped at zero
  always_comb begin
    s4_y = dv_sb.neg ? dv_sb.base - $signed(YW'(dv_q))
                     : dv_sb.base + $signed(YW'(dv_q));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_z_r   <= (s4_y < 0) ? '0 : ZW'(s4_y);
    s4_oor_r <= dv_sb.oor;
  end

  lli_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_valid_r),
    .in_z      (s4_z_r),
    .in_oor    (s4_oor_r),
    .out_valid (ex_valid),
    .out_mant  (ex_mant),
    .out_sb    (ex_sb)
  );

  // scale the mantissa by the integer exponent, saturate at 32 bits
  always_comb begin
    s5_sh   = ex_sb.k - KW'(QBITS);
    s5_wide = (2*CW)'(ex_mant) << s5_sh;
    if (ex_sb.k >= KW'(QBITS)) begin
      if (s5_sh >= KW'(CW) || s5_wide[2*CW-1:CW] != '0) begin
        s5_res = '1;
      end else begin
        s5_res = s5_wide[CW-1:0];
      end
    end else begin
      s5_res = CW'(ex_mant >> (KW'(QBITS) - ex_sb.k));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ex_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r.coefficient  <= s5_res;
    out_rsp_r.out_of_range <= ex_sb.oor;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

### hw/rtl/lli_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the interpolator, bound to the top level.
module lli_checker
  import lli_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input lli_in_t  in_req,
  input logic     out_valid,
  input lli_out_t out_rsp
);

  // every response traces back to a request a fixed latency earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("response without a matching request");

  // every request yields its response after the fixed latency
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("request lost in the pipeline");

  // range flag follows the request's energy
  a_range_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.out_of_range ==
      $past(32'(in_req.energy_ev) < GRID_EV[0] ||
            32'(in_req.energy_ev) > GRID_EV[TABLE_POINTS-1], LATENCY))
    else $error("out_of_range does not match the request");

  // reset empties the pipeline and raises busy to block requests
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (busy && !out_valid))
    else $error("pipeline not cleared by reset");

endmodule

bind log_log_coefficient_interpolator lli_checker u_lli_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for the dry-air log-log coefficient interpolator: directed table, then random requests.
module tb;
  import lli_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  lli_in_t  in_req;
  logic     out_valid;
  lli_out_t out_rsp;

  log_log_coefficient_interpolator i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  localparam logic OP_ATTEN  = 1'b0;
  localparam logic OP_ABSORB = 1'b1;

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  lli_out_t coeff_q[$];
  int       errors = 0;
  int       n_mismatch = 0;

  // Q30 log2 by squaring the mantissa, each square truncated
  function automatic longint log2_fx(input longint unsigned x);
    longint unsigned m;
    longint          r;
    int              n;
    if (x == 0) x = 1;
    n = 0;
    while (n < 31 && (x >> (n + 1)) != 0) n++;
    m = (x << 30) >> n;
    r = longint'(n) << 30;
    for (int b = 29; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r += longint'(1) << b;
      end
    end
    return r;
  endfunction

  // 2^f of the Q30 fraction via a series up to the 16th power
  function automatic longint unsigned exp2_fx(input longint unsigned f);
    longint unsigned x, sum, term;
    x = ((f & ((64'd1 << 30) - 1)) * 64'd744261118) >> 30;
    sum = 64'd1 << 30;
    term = sum;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * x) >> 30) / n;
      sum += term;
    end
    return sum;
  endfunction

  function automatic lli_out_t interp_coeff(input lli_in_t rq);
    logic [31:0]     e, v_lo, v_hi;
    int              hi;
    longint          y, z, num, den, dv, lo_v;
    longint unsigned mag, dl, k, mant, res;
    lli_out_t        o;
    e = 32'(rq.energy_ev);
    if (e <= GRID_EV[0]) begin
      y = log2_fx(rq.operation ? ABSORB_MICRO[0] : ATTEN_MICRO[0]);
    end else if (e >= GRID_EV[TABLE_POINTS-1]) begin
      y = log2_fx(rq.operation ? ABSORB_MICRO[TABLE_POINTS-1] : ATTEN_MICRO[TABLE_POINTS-1]);
    end else begin
      hi = 1;
      while (hi < TABLE_POINTS - 1 && GRID_EV[hi] < e) hi++;
      v_lo = rq.operation ? ABSORB_MICRO[hi-1] : ATTEN_MICRO[hi-1];
      v_hi = rq.operation ? ABSORB_MICRO[hi] : ATTEN_MICRO[hi];
      num = log2_fx(e) - log2_fx(GRID_EV[hi-1]);
      den = log2_fx(GRID_EV[hi]) - log2_fx(GRID_EV[hi-1]);
      lo_v = log2_fx(v_lo);
      dv = log2_fx(v_hi) - lo_v;
      if (num < 0) num = 0;
      if (den <= 0) begin
        dl = 0;
      end else begin
        if (num > den) num = den;
        mag = dv < 0 ? -dv : dv;
        dl = (unsigned'(num) * mag) / unsigned'(den);
      end
      y = dv < 0 ? lo_v - longint'(dl) : lo_v + longint'(dl);
    end
    z = y + (longint'(COEFF_FRAC_BITS) << 30) - log2_fx(MICRO_SCALE);
    if (z < 0) z = 0;
    k = unsigned'(z) >> 30;
    mant = exp2_fx(z);
    if (k >= 30) begin
      if (k - 30 >= 32) res = 64'hFFFF_FFFF;
      else begin
        res = mant << (k - 30);
        if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
      end
    end else begin
      res = mant >> (30 - k);
      if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
    end
    o.coefficient = res[31:0];
    o.out_of_range = (e < GRID_EV[0] || e > GRID_EV[TABLE_POINTS-1]);
    return o;
  endfunction

  // directed rows; fixed expectation where check_fixed is set
  typedef struct {
    lli_in_t  rq;
    logic     check_fixed;
    lli_out_t fixed;
  } dir_row_t;

  dir_row_t dir_tab[$];

  function automatic lli_in_t mk_req(input int e, input logic op);
    lli_in_t r;
    r.energy_ev = EW'(e);
    r.operation = op;
    return r;
  endfunction

  task automatic add_row(input int e, input logic op);
    dir_row_t d;
    d.rq = mk_req(e, op);
    d.check_fixed = 1'b0;
    d.fixed = '0;
    dir_tab.push_back(d);
  endtask

  task automatic add_fixed(input int e, input logic op, input lli_out_t x);
    dir_row_t d;
    d.rq = mk_req(e, op);
    d.check_fixed = 1'b1;
    d.fixed = x;
    dir_tab.push_back(d);
  endtask

  // random gap, mostly short; start drops only when there is a gap
  task automatic idle_gap();
    int g;
    if ($urandom_range(0, 3) != 0) g = 0;
    else if ($urandom_range(0, 9) != 0) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 60);
    if (g != 0) begin
      start <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // drive one request at the falling edge, held until taken
  task automatic send_req(input lli_in_t rq, input logic use_fixed, input lli_out_t fx);
    start <= 1'b1;
    in_req <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    coeff_q.push_back(use_fixed ? fx : interp_coeff(rq));
    @(negedge clk);
  endtask

  // response check
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (coeff_q.size() == 0) begin
        errors++;
        if (n_mismatch++ < 10) $display("unexpected response %h", out_rsp);
      end else begin
        lli_out_t x;
        x = coeff_q.pop_front();
        if (x.coefficient !== out_rsp.coefficient || x.out_of_range !== out_rsp.out_of_range) begin
          errors++;
          if (n_mismatch++ < 10)
            $display("mismatch: exp coeff %0d oor %b, got coeff %0d oor %b",
                     x.coefficient, x.out_of_range, out_rsp.coefficient, out_rsp.out_of_range);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("tb failed");
    $finish;
  end

  initial begin
    lli_out_t fx;
    lli_in_t  rq;
    int       e, hi;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // low end: zero and below the grid are flagged
    fx = interp_coeff(mk_req(0, OP_ATTEN));
    fx.out_of_range = 1'b1;
    add_fixed(0, OP_ATTEN, fx);
    add_fixed(1, OP_ATTEN, fx);
    add_fixed(9999, OP_ATTEN, fx);
    fx.out_of_range = 1'b0;
    add_fixed(10000, OP_ATTEN, fx);
    fx = interp_coeff(mk_req(0, OP_ABSORB));
    fx.out_of_range = 1'b1;
    add_fixed(0, OP_ABSORB, fx);
    fx.out_of_range = 1'b0;
    add_fixed(10000, OP_ABSORB, fx);
    // high end, field maximum
    fx = interp_coeff(mk_req(10000000, OP_ATTEN));
    add_fixed(10000000, OP_ATTEN, fx);
    fx.out_of_range = 1'b1;
    add_fixed(10000001, OP_ATTEN, fx);
    add_fixed(16777215, OP_ATTEN, fx);
    fx = interp_coeff(mk_req(10000000, OP_ABSORB));
    fx.out_of_range = 1'b1;
    add_fixed(16777215, OP_ABSORB, fx);
    // interior grid points and their neighbors
    add_row(10001, OP_ATTEN);
    add_row(15000, OP_ATTEN);
    add_row(15001, OP_ABSORB);
    add_row(100000, OP_ABSORB);
    add_row(1000000, OP_ATTEN);
    add_row(1250000, OP_ABSORB);
    add_row(9999999, OP_ATTEN);
    add_row(9999999, OP_ABSORB);
    add_row(8000000, OP_ABSORB);
    add_row(12345, OP_ABSORB);

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].rq, dir_tab[i].check_fixed, dir_tab[i].fixed);
      idle_gap();
    end

    // random requests, mostly inside the grid, some bursts
    for (int n = 0; n < 500; n++) begin
      case ($urandom_range(0, 9))
        0: e = $urandom_range(0, 16777215);
        1: e = $urandom_range(0, 10000);
        2: e = $urandom_range(10000000, 16777215);
        3: begin
          hi = $urandom_range(0, TABLE_POINTS - 1);
          e = GRID_EV[hi] + $urandom_range(0, 2) - 1;
        end
        default: e = $urandom_range(10000, 10000000);
      endcase
      rq = mk_req(e, 1'($urandom_range(0, 1)));
      send_req(rq, 1'b0, '0);
      if ($urandom_range(0, 2) == 0) begin
        idle_gap();
      end
    end
    start <= 1'b0;

    while (coeff_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

### sim.f
hw/rtl/lli_pkg.sv
hw/rtl/lli_log2.sv
hw/rtl/lli_div.sv
hw/rtl/lli_exp.sv
hw/rtl/log_log_coefficient_interpolator.sv
hw/rtl/lli_checker.sv
tb/sv/tb.sv
